### rtl/core/tbp_pkg.sv
// Shared constants and counter helpers for the tournament branch predictor.
// No dependencies; used by the predictor top level and the checker in rtl/core.
`default_nettype none

package tbp_pkg;

    localparam int unsigned BHT_INDEX_BITS_DEF = 15;
    localparam int unsigned PHT_INDEX_BITS_DEF = 15;
    localparam int unsigned HISTORY_BITS_DEF   = 64;
    localparam int unsigned COUNTER_BITS_DEF   = 2;
    localparam int unsigned CHOOSER_BITS_DEF   = 2;

    localparam int unsigned PC_BITS = 64;
    localparam int unsigned IN_DATA_BITS = 72;
    localparam int unsigned OUT_DATA_BITS = 8;
    localparam int unsigned RESULT_BITS = 4;

    // Bit positions of the result beat
    localparam int unsigned RES_PREDICTION = 0;
    localparam int unsigned RES_BIMODAL    = 1;
    localparam int unsigned RES_GLOBAL     = 2;
    localparam int unsigned RES_USED_GLOBAL = 3;

    typedef logic [7:0] ctr_t;

    function automatic ctr_t ctr_mid(input int unsigned w);
        return ctr_t'(1 << (w - 1));
    endfunction

    function automatic ctr_t ctr_max(input int unsigned w);
        return ctr_t'((1 << w) - 1);
    endfunction

    function automatic logic ctr_taken(input ctr_t v, input int unsigned w);
        return v >= ctr_mid(w);
    endfunction

    // Weak-not-taken jumps to strong taken; otherwise saturating increment
    function automatic ctr_t ctr_up(input ctr_t v, input int unsigned w);
        ctr_t r;
        r = v;
        if (v == ctr_t'(ctr_mid(w) - 8'd1))
            r = ctr_max(w);
        else if (v < ctr_max(w))
            r = v + 8'd1;
        return r;
    endfunction

    // Weak-taken jumps to strong not-taken; otherwise saturating decrement
    function automatic ctr_t ctr_down(input ctr_t v, input int unsigned w);
        ctr_t r;
        r = v;
        if (v == ctr_mid(w))
            r = 8'd0;
        else if (v > 8'd0)
            r = v - 8'd1;
        return r;
    endfunction

    function automatic ctr_t ctr_train(input ctr_t v, input int unsigned w, input logic up);
        return up ? ctr_up(v, w) : ctr_down(v, w);
    endfunction

endpackage

`default_nettype wire

### rtl/core/tbp_ram.sv
// Simple dual-port counter table: one synchronous write, one registered read.
// No dependencies; instantiated twice by the predictor top level.
`default_nettype none

module tbp_ram #(
    parameter int unsigned ADDR_BITS = 15,
    parameter int unsigned DATA_BITS = 2
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read-during-write returns the old contents
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/tournament_branch_predictor_unit.sv
// Tournament branch predictor: bimodal and gshare tables with a global chooser.
// Depends on tbp_pkg and tbp_ram.
//
// Usage:
//   s_axis carries one resolved conditional branch per beat: pc and its actual
//   direction. m_axis returns one beat per input beat, in order, holding the
//   prediction the block would have made before learning that outcome, the
//   two component guesses and which component the chooser picked.
//   Each beat is registered in stage 1 and then written into the result queue;
//   one branch is taken per cycle, sustained, while s_axis_tready is high. The
//   rate is set by the single read/write port pair of each counter table: the
//   read issues on the accept cycle, the trained counter is written back the
//   cycle after, and a write to the entry the following beat reads is forwarded.
//   After reset (rst_n low) both tables are swept to weak taken, one entry a
//   cycle through every entry; s_axis_tready stays low during the sweep. History
//   clears to zero and the chooser to weak taken.
//   A four-beat result queue sits before m_axis; when the receiver stalls the
//   queue fills and s_axis_tready drops once it cannot absorb more beats.
`default_nettype none

module tournament_branch_predictor_unit #(
    parameter int unsigned BHT_INDEX_BITS = tbp_pkg::BHT_INDEX_BITS_DEF,
    parameter int unsigned PHT_INDEX_BITS = tbp_pkg::PHT_INDEX_BITS_DEF,
    parameter int unsigned HISTORY_BITS   = tbp_pkg::HISTORY_BITS_DEF,
    parameter int unsigned COUNTER_BITS   = tbp_pkg::COUNTER_BITS_DEF,
    parameter int unsigned CHOOSER_BITS   = tbp_pkg::CHOOSER_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [63:0] pc, [64] taken, [71:65] zero
    input  wire logic [tbp_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] prediction, [1] bimodal_guess, [2] global_guess, [3] used_global, [7:4] zero
    output logic [tbp_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata
);

    localparam int unsigned CLR_BITS =
        (BHT_INDEX_BITS > PHT_INDEX_BITS) ? BHT_INDEX_BITS : PHT_INDEX_BITS;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_BITS = 2;
    localparam int unsigned Q_CNT_BITS = 3;

    localparam logic [COUNTER_BITS-1:0] CTR_MID =
        COUNTER_BITS'(tbp_pkg::ctr_mid(COUNTER_BITS));
    localparam logic [CHOOSER_BITS-1:0] CHO_MID =
        CHOOSER_BITS'(tbp_pkg::ctr_mid(CHOOSER_BITS));

    // ---------------- input decode ----------------
    logic [tbp_pkg::PC_BITS-1:0] in_pc;
    logic                        in_taken;
    logic                        in_accept;
    logic [tbp_pkg::PC_BITS-1:0] hist_wide;
    logic [BHT_INDEX_BITS-1:0]   in_bidx;
    logic [PHT_INDEX_BITS-1:0]   in_gidx;

    logic [HISTORY_BITS-1:0]     history_reg;
    logic [HISTORY_BITS-1:0]     history_next;

    logic                        clearing_reg;
    logic [CLR_BITS-1:0]         clear_cnt_reg;

    logic [Q_CNT_BITS-1:0]       q_count_reg;
    logic [Q_CNT_BITS-1:0]       q_count_next;
    logic [Q_CNT_BITS-1:0]       occupancy;

    assign in_pc     = s_axis_tdata[tbp_pkg::PC_BITS-1:0];
    assign in_taken  = s_axis_tdata[tbp_pkg::PC_BITS];
    assign hist_wide = tbp_pkg::PC_BITS'(history_reg);
    assign in_bidx   = BHT_INDEX_BITS'(in_pc >> 2);
    assign in_gidx   = PHT_INDEX_BITS'(hist_wide ^ in_pc);
    assign history_next = HISTORY_BITS'({history_reg, in_taken});

    logic s1_valid_reg;

    assign occupancy     = q_count_reg + Q_CNT_BITS'(s1_valid_reg);
    assign s_axis_tready = !clearing_reg && (occupancy < Q_CNT_BITS'(Q_DEPTH));
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ---------------- stage 1 registers ----------------
    logic [BHT_INDEX_BITS-1:0] s1_bidx_reg;
    logic [PHT_INDEX_BITS-1:0] s1_gidx_reg;
    logic                      s1_taken_reg;

    logic                      wb_valid_reg;
    logic [BHT_INDEX_BITS-1:0] wb_bidx_reg;
    logic [PHT_INDEX_BITS-1:0] wb_gidx_reg;
    logic [COUNTER_BITS-1:0]   wb_bval_reg;
    logic [COUNTER_BITS-1:0]   wb_gval_reg;

    logic [CHOOSER_BITS-1:0]   chooser_reg;
    logic [CHOOSER_BITS-1:0]   chooser_next;

    logic [COUNTER_BITS-1:0]   b_rdata;
    logic [COUNTER_BITS-1:0]   g_rdata;
    logic [COUNTER_BITS-1:0]   b_cur;
    logic [COUNTER_BITS-1:0]   g_cur;
    logic [COUNTER_BITS-1:0]   b_new;
    logic [COUNTER_BITS-1:0]   g_new;
    logic                      bguess;
    logic                      gguess;
    logic                      use_g;
    logic                      pred;
    logic [tbp_pkg::RESULT_BITS-1:0] s1_result;

    // Forward the counter written on the same edge this beat's read issued
    assign b_cur = (wb_valid_reg && (wb_bidx_reg == s1_bidx_reg)) ? wb_bval_reg : b_rdata;
    assign g_cur = (wb_valid_reg && (wb_gidx_reg == s1_gidx_reg)) ? wb_gval_reg : g_rdata;

    always_comb
    begin
        bguess = tbp_pkg::ctr_taken(tbp_pkg::ctr_t'(b_cur), COUNTER_BITS);
        gguess = tbp_pkg::ctr_taken(tbp_pkg::ctr_t'(g_cur), COUNTER_BITS);
        use_g  = tbp_pkg::ctr_taken(tbp_pkg::ctr_t'(chooser_reg), CHOOSER_BITS);
        pred   = use_g ? gguess : bguess;
        b_new  = COUNTER_BITS'(tbp_pkg::ctr_train(tbp_pkg::ctr_t'(b_cur), COUNTER_BITS,
                                                  s1_taken_reg));
        g_new  = COUNTER_BITS'(tbp_pkg::ctr_train(tbp_pkg::ctr_t'(g_cur), COUNTER_BITS,
                                                  s1_taken_reg));
        chooser_next = chooser_reg;
        if (s1_valid_reg)
        begin
            if ((bguess == s1_taken_reg) && (gguess != s1_taken_reg))
                chooser_next = CHOOSER_BITS'(tbp_pkg::ctr_down(
                    tbp_pkg::ctr_t'(chooser_reg), CHOOSER_BITS));
            else if ((bguess != s1_taken_reg) && (gguess == s1_taken_reg))
                chooser_next = CHOOSER_BITS'(tbp_pkg::ctr_up(
                    tbp_pkg::ctr_t'(chooser_reg), CHOOSER_BITS));
        end
        s1_result = '0;
        s1_result[tbp_pkg::RES_PREDICTION]  = pred;
        s1_result[tbp_pkg::RES_BIMODAL]     = bguess;
        s1_result[tbp_pkg::RES_GLOBAL]      = gguess;
        s1_result[tbp_pkg::RES_USED_GLOBAL] = use_g;
    end

    // ---------------- table write port ----------------
    logic                      tbl_we;
    logic [BHT_INDEX_BITS-1:0] b_waddr;
    logic [PHT_INDEX_BITS-1:0] g_waddr;
    logic [COUNTER_BITS-1:0]   b_wdata;
    logic [COUNTER_BITS-1:0]   g_wdata;

    assign tbl_we  = clearing_reg || s1_valid_reg;
    assign b_waddr = clearing_reg ? clear_cnt_reg[BHT_INDEX_BITS-1:0] : s1_bidx_reg;
    assign g_waddr = clearing_reg ? clear_cnt_reg[PHT_INDEX_BITS-1:0] : s1_gidx_reg;
    assign b_wdata = clearing_reg ? CTR_MID : b_new;
    assign g_wdata = clearing_reg ? CTR_MID : g_new;

    tbp_ram #(
        .ADDR_BITS (BHT_INDEX_BITS),
        .DATA_BITS (COUNTER_BITS)
    ) u_bimodal (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (in_bidx),
        .rdata (b_rdata)
    );

    tbp_ram #(
        .ADDR_BITS (PHT_INDEX_BITS),
        .DATA_BITS (COUNTER_BITS)
    ) u_pattern (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (in_gidx),
        .rdata (g_rdata)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
            history_reg   <= '0;
            chooser_reg   <= CHO_MID;
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + CLR_BITS'(1);
                if (&clear_cnt_reg)
                    clearing_reg <= 1'b0;
            end
            if (in_accept)
                history_reg <= history_next;
            chooser_reg  <= chooser_next;
            s1_valid_reg <= in_accept;
            wb_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_bidx_reg  <= in_bidx;
        s1_gidx_reg  <= in_gidx;
        s1_taken_reg <= in_taken;
        wb_bidx_reg  <= s1_bidx_reg;
        wb_gidx_reg  <= s1_gidx_reg;
        wb_bval_reg  <= b_new;
        wb_gval_reg  <= g_new;
    end

    // ---------------- result queue ----------------
    logic [tbp_pkg::RESULT_BITS-1:0] q_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]           q_wr_ptr_reg;
    logic [Q_PTR_BITS-1:0]           q_rd_ptr_reg;
    logic                            q_pop;

    assign m_axis_tvalid = (q_count_reg != '0);
    assign q_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = tbp_pkg::OUT_DATA_BITS'(q_mem[q_rd_ptr_reg]);
    assign q_count_next  = q_count_reg + Q_CNT_BITS'(s1_valid_reg) - Q_CNT_BITS'(q_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg  <= '0;
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (s1_valid_reg)
                q_wr_ptr_reg <= q_wr_ptr_reg + Q_PTR_BITS'(1);
            if (q_pop)
                q_rd_ptr_reg <= q_rd_ptr_reg + Q_PTR_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            q_mem[q_wr_ptr_reg] <= s1_result;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tbp_checker.sv
// Port-level checks for the tournament branch predictor, bound to the top level.
// Depends on tbp_pkg and tournament_branch_predictor_unit.
`default_nettype none

module tbp_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [tbp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    logic [3:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // Track beats taken in but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 4'(in_beat) - 4'(out_beat);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_pred_select: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[tbp_pkg::RES_PREDICTION] ==
            (m_axis_tdata[tbp_pkg::RES_USED_GLOBAL] ? m_axis_tdata[tbp_pkg::RES_GLOBAL]
                                                    : m_axis_tdata[tbp_pkg::RES_BIMODAL]))
        else $error("prediction does not follow chooser selection");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 4'd0)
        else $error("result beat with no outstanding branch");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd5)
        else $error("too many branches in flight");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[tbp_pkg::OUT_DATA_BITS-1:tbp_pkg::RESULT_BITS] == '0)
        else $error("result padding not zero");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
